@@ rtl/wrc_pkg.sv @@
// write request coalescer package: field widths, request and result types
// no dependencies
package wrc_pkg;

  localparam int OFFSET_W = 32;
  localparam int LEN_W    = 25;
  localparam int END_W    = OFFSET_W + 1;
  localparam int COUNT_W  = 16;

  localparam logic [LEN_W-1:0]   LIMIT_RESET = LEN_W'(1048576);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  typedef enum logic {
    CAUSE_SIZE_LIMIT = 1'b0,
    CAUSE_EXPIRED    = 1'b1
  } cause_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    length;
    logic                retry_pending;
    logic                force_expire;
    logic                deadline_passed;
    logic                end_of_list;
  } wrc_req_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] group_offset;
    logic [LEN_W-1:0]    group_bytes;
    logic [COUNT_W-1:0]  request_count;
    cause_t              cause;
    logic                last_of_run;
  } wrc_res_t;

  // up to two results per request, v1 only with v0
  typedef struct packed {
    logic     v0;
    logic     v1;
    wrc_res_t r0;
    wrc_res_t r1;
  } wrc_push_t;

endpackage

@@ rtl/wrc_if.sv @@
// channel interfaces of the write request coalescer: request, result, config write
// depends on wrc_pkg
interface wrc_req_if;
  import wrc_pkg::*;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] offset;
  logic [LEN_W-1:0]    length;
  logic                retry_pending;
  logic                force_expire;
  logic                deadline_passed;
  logic                end_of_list;

  modport source (output valid, offset, length, retry_pending, force_expire,
                  deadline_passed, end_of_list, input ready);
  modport sink (input valid, offset, length, retry_pending, force_expire,
                deadline_passed, end_of_list, output ready);
endinterface

interface wrc_res_if;
  import wrc_pkg::*;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] group_offset;
  logic [LEN_W-1:0]    group_bytes;
  logic [COUNT_W-1:0]  request_count;
  logic                cause;
  logic                last_of_run;

  modport source (output valid, group_offset, group_bytes, request_count, cause,
                  last_of_run, input ready);
  modport sink (input valid, group_offset, group_bytes, request_count, cause,
                last_of_run, output ready);
endinterface

interface wrc_cfg_if;
  import wrc_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] coalesce_limit;

  modport source (output valid, coalesce_limit, input ready);
  modport sink (input valid, coalesce_limit, output ready);
endinterface

@@ rtl/wrc_group_engine.sv @@
// group state registers and the single-pass update for one accepted request
// depends on wrc_pkg
module wrc_group_engine import wrc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_fire,
  input  wrc_req_t         req,
  input  logic [LEN_W-1:0] limit,
  output wrc_push_t        push
);

  logic                open_r, open_nxt;
  logic [OFFSET_W-1:0] start_r, start_nxt;
  logic [LEN_W-1:0]    size_r, size_nxt;
  logic [END_W-1:0]    fe_r, fe_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                expired_r, expired_nxt;
  logic                halted_r, halted_nxt;

  logic             cur_exp;
  logic             eff;
  logic [END_W-1:0] req_end;
  logic             overlap;
  logic             grows;
  logic [LEN_W-1:0] grow;
  logic [LEN_W:0]   grown;
  logic             over;
  logic [COUNT_W-1:0] count_inc;
  logic             start_new;
  logic             a_v, b_v;
  cause_t           a_cause;
  wrc_res_t         res_a, res_b;

  always_comb begin
    cur_exp   = req.force_expire | req.deadline_passed;
    eff       = expired_r | cur_exp;
    req_end   = {1'b0, req.offset} + END_W'(req.length);
    overlap   = {1'b0, req.offset} <= fe_r;
    grows     = req_end > fe_r;
    grow      = req_end[LEN_W-1:0] - fe_r[LEN_W-1:0];
    grown     = {1'b0, size_r} + {1'b0, grow};
    over      = grown > {1'b0, limit};
    count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

    open_nxt    = open_r;
    start_nxt   = start_r;
    size_nxt    = size_r;
    fe_nxt      = fe_r;
    count_nxt   = count_r;
    expired_nxt = expired_r;
    halted_nxt  = halted_r;
    start_new   = 1'b0;
    a_v         = 1'b0;
    b_v         = 1'b0;
    a_cause     = CAUSE_EXPIRED;

    if (req_fire) begin
      if (halted_r) begin
        if (req.end_of_list) begin
          halted_nxt = 1'b0;
        end
      end else begin
        if (req.retry_pending && !req.deadline_passed) begin
          a_v         = open_r & expired_r;
          open_nxt    = 1'b0;
          expired_nxt = 1'b0;
          halted_nxt  = !req.end_of_list;
        end else if (!open_r) begin
          start_new = 1'b1;
        end else if (overlap) begin
          if (grows && over) begin
            a_v       = 1'b1;
            a_cause   = CAUSE_SIZE_LIMIT;
            start_new = 1'b1;
          end else begin
            if (grows) begin
              size_nxt = grown[LEN_W-1:0];
              fe_nxt   = req_end;
            end
            count_nxt   = count_inc;
            expired_nxt = eff;
          end
        end else begin
          a_v       = eff;
          start_new = 1'b1;
        end

        if (start_new) begin
          open_nxt    = 1'b1;
          start_nxt   = req.offset;
          size_nxt    = req.length;
          fe_nxt      = req_end;
          count_nxt   = COUNT_W'(1);
          expired_nxt = cur_exp;
        end

        if (req.end_of_list) begin
          b_v         = open_nxt & expired_nxt;
          open_nxt    = 1'b0;
          expired_nxt = 1'b0;
        end
      end
    end

    res_a = '{group_offset: start_r, group_bytes: size_r, request_count: count_r,
              cause: a_cause, last_of_run: 1'b0};
    res_b = '{group_offset: start_nxt, group_bytes: size_nxt, request_count: count_nxt,
              cause: CAUSE_EXPIRED, last_of_run: 1'b1};

    push.v0 = a_v | b_v;
    push.v1 = a_v & b_v;
    push.r0 = a_v ? res_a : res_b;
    push.r0.last_of_run = !(a_v & b_v);
    push.r1 = res_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      expired_r <= 1'b0;
      halted_r  <= 1'b0;
    end else begin
      open_r    <= open_nxt;
      expired_r <= expired_nxt;
      halted_r  <= halted_nxt;
    end
  end

  // group payload, only read while the group is open
  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    size_r  <= size_nxt;
    fe_r    <= fe_nxt;
    count_r <= count_nxt;
  end

endmodule

@@ rtl/wrc_result_fifo.sv @@
// result queue: takes up to two results a cycle, gives one per pop
// depends on wrc_pkg
module wrc_result_fifo import wrc_pkg::*; #(
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wrc_push_t        push,
  input  logic             pop,
  output logic             room,
  output logic             out_valid,
  output wrc_res_t         out_res,
  output logic [CNT_W-1:0] level
);

  wrc_res_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] level_r, level_nxt;
  logic             pop_fire;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    pop_fire   = pop & (level_r != '0);
    level_nxt  = level_r + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop_fire);
    wr_ptr_nxt = push.v1 ? ptr_inc(ptr_inc(wr_ptr_r)) :
                 push.v0 ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? ptr_inc(rd_ptr_r) : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      mem[ptr_inc(wr_ptr_r)] <= push.r1;
    end
  end

  assign room      = level_r <= CNT_W'(DEPTH - 2);
  assign out_valid = level_r != '0;
  assign out_res   = mem[rd_ptr_r];
  assign level     = level_r;

endmodule

@@ rtl/write_request_coalescer_core.sv @@
// write request coalescer top level: config register, group engine, result queue
// depends on wrc_pkg, wrc_if, wrc_group_engine, wrc_result_fifo
//
// Usage:
//   in_req  takes offset-sorted write requests, one per valid/ready handshake.
//   out_res returns coalesced transfers; a request gives zero, one or two of
//           them, last_of_run marks the final one of each request.
//   cfg_wr  writes coalesce_limit; always ready, write only while idle.
// Results of a taken request are registered in the queue and offered in order.
// Throughput: one request per cycle while in_req.ready, set by the combinational
//   group update on the registered state; results leave one per cycle when taken
// Stall: results queue in a FIFO_DEPTH-entry buffer; in_req.ready drops while
//   fewer than two entries are free, so nothing is lost while out_res stalls.
// Reset: rst_n synchronous, active low; clears the group, the halt mark and
//   the queue, and loads coalesce_limit with 1048576.
module write_request_coalescer_core import wrc_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  wrc_req_if.sink  in_req,
  wrc_res_if.source out_res,
  wrc_cfg_if.sink  cfg_wr
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [LEN_W-1:0] limit_r;
  logic             req_fire;
  wrc_req_t         req;
  wrc_push_t        push;
  logic             room;
  logic             res_valid;
  wrc_res_t         res;
  logic [CNT_W-1:0] level;

  // configuration register
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr.valid) begin
      limit_r <= cfg_wr.coalesce_limit;
    end
  end

  assign in_req.ready = room;
  assign req_fire     = in_req.valid & room;
  assign req = '{offset: in_req.offset, length: in_req.length,
                 retry_pending: in_req.retry_pending, force_expire: in_req.force_expire,
                 deadline_passed: in_req.deadline_passed,
                 end_of_list: in_req.end_of_list};

  wrc_group_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_fire (req_fire),
    .req      (req),
    .limit    (limit_r),
    .push     (push)
  );

  wrc_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_res.ready),
    .room      (room),
    .out_valid (res_valid),
    .out_res   (res),
    .level     (level)
  );

  assign out_res.valid         = res_valid;
  assign out_res.group_offset  = res.group_offset;
  assign out_res.group_bytes   = res.group_bytes;
  assign out_res.request_count = res.request_count;
  assign out_res.cause         = res.cause;
  assign out_res.last_of_run   = res.last_of_run;

  // results only come from an accepted request
  a_push_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    push.v0 |-> req_fire)
    else $error("result produced without an accepted request");

  // a second result only follows a first
  a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0)
    else $error("second result without first");

  // queue never holds more than its depth
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    level <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // a queued result leaves only when taken
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !out_res.ready && !push.v0) |=> res_valid && $stable(res))
    else $error("waiting result changed while stalled");

endmodule
